// ----- rtl/mbrs_pkg.sv -----
// shared types, constants and the crc-16 fold for the modbus rtu register slave
// no dependencies
`default_nettype none
package mbrs_pkg;

   // modbus function codes served
   localparam logic [7:0] FUNC_READ_HOLD   = 8'h03;
   localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam int          HDR_BYTES = 7;
   localparam logic [7:0]  WDATA_OFFSET = 8'd7;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_MULTI  = 2'd2
   } kind_type;

   // one validated request handed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] addr_hi;
      logic [7:0] addr_lo;
      logic [7:0] qty_hi;
      logic [7:0] qty_lo;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_WR_ISSUE = 3'd1,
      ST_WR_HI    = 3'd2,
      ST_WR_LO    = 3'd3,
      ST_HEAD     = 3'd4,
      ST_DATA     = 3'd5,
      ST_CRC_LO   = 3'd6,
      ST_CRC_HI   = 3'd7
   } back_state_type;

   // reflected crc-16, one byte
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mbrs_front.sv -----
// receive side: frame buffer, running crc, header capture and request check
// depends on mbrs_pkg
`default_nettype none
module mbrs_front #(
   parameter int FRAME_BYTES = 64,
   parameter int REG_COUNT   = 16,
   parameter int AW          = 6
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic                req_frame_end,
   input  wire logic [7:0]          slave_id,
   input  wire logic                queue_full,
   output logic                     push,
   output mbrs_pkg::job_type        push_job,
   input  wire logic                multi_done,
   input  wire logic [AW-1:0]       rd_addr,
   output logic [7:0]               rd_data
);
   localparam int LW = $clog2(FRAME_BYTES + 1);

   logic [7:0]    mem [FRAME_BYTES];
   logic [LW-1:0] length_ff, length_in;
   logic [15:0]   crc_ff, crc_in;
   logic          ovf_ff, ovf_in;
   logic          multi_pend_ff, multi_pend_in;
   logic [7:0]    hdr_ff [mbrs_pkg::HDR_BYTES];
   logic [7:0]    hdr_now [mbrs_pkg::HDR_BYTES];
   logic          accept, room, ovf_now;
   logic [LW-1:0] len_now;
   logic [15:0]   crc_now, addr_w, qty_w;
   logic [16:0]   span;
   logic [17:0]   multi_len;
   logic          span_ok, ok_read, ok_single, ok_multi, frame_ok;

   assign req_stall = queue_full | multi_pend_ff;
   assign accept    = req_valid & ~req_stall;
   assign room      = length_ff < LW'(FRAME_BYTES);

   // header bytes including the one arriving now
   always_comb begin
      for (int k = 0; k < mbrs_pkg::HDR_BYTES; k++) begin
         hdr_now[k] = (room && length_ff == LW'(k)) ? req_rx_byte : hdr_ff[k];
      end
   end

   assign len_now = room ? length_ff + LW'(1) : length_ff;
   assign ovf_now = ovf_ff | ~room;
   assign crc_now = mbrs_pkg::crc_fold(crc_ff, req_rx_byte);
   assign addr_w  = {hdr_now[2], hdr_now[3]};
   assign qty_w   = {hdr_now[4], hdr_now[5]};
   assign span    = {1'b0, addr_w} + {1'b0, qty_w};
   assign span_ok = (qty_w != 16'd0) && (span <= 17'(REG_COUNT));
   assign multi_len = 18'd9 + {1'b0, qty_w, 1'b0};

   // frame check at frame end
   always_comb begin
      frame_ok  = !ovf_now && (len_now >= LW'(4)) && (hdr_now[0] == slave_id)
                  && (crc_now == 16'd0);
      ok_read   = (hdr_now[1] == mbrs_pkg::FUNC_READ_HOLD) && (len_now == LW'(8)) && span_ok;
      ok_single = (hdr_now[1] == mbrs_pkg::FUNC_WRITE_SINGLE) && (len_now == LW'(8))
                  && (addr_w < 16'(REG_COUNT));
      ok_multi  = (hdr_now[1] == mbrs_pkg::FUNC_WRITE_MULTI) && span_ok
                  && (18'(len_now) == multi_len)
                  && ({10'd0, hdr_now[6]} == {1'b0, qty_w, 1'b0});
      push = accept && req_frame_end && frame_ok && (ok_read || ok_single || ok_multi);
      push_job.kind    = ok_multi ? mbrs_pkg::KIND_MULTI :
                         ok_single ? mbrs_pkg::KIND_SINGLE : mbrs_pkg::KIND_READ;
      push_job.addr_hi = hdr_now[2];
      push_job.addr_lo = hdr_now[3];
      push_job.qty_hi  = hdr_now[4];
      push_job.qty_lo  = hdr_now[5];
   end

   // receive state next values
   always_comb begin
      length_in     = length_ff;
      crc_in        = crc_ff;
      ovf_in        = ovf_ff;
      multi_pend_in = multi_pend_ff & ~multi_done;
      if (accept) begin
         if (req_frame_end) begin
            length_in = '0;
            crc_in    = mbrs_pkg::CRC_INIT;
            ovf_in    = 1'b0;
         end else begin
            length_in = len_now;
            crc_in    = crc_now;
            ovf_in    = ovf_now;
         end
      end
      if (push && push_job.kind == mbrs_pkg::KIND_MULTI) begin
         multi_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         crc_ff        <= mbrs_pkg::CRC_INIT;
         ovf_ff        <= 1'b0;
         multi_pend_ff <= 1'b0;
      end else begin
         length_ff     <= length_in;
         crc_ff        <= crc_in;
         ovf_ff        <= ovf_in;
         multi_pend_ff <= multi_pend_in;
      end
   end

   // header copy
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < mbrs_pkg::HDR_BYTES; k++) begin
            hdr_ff[k] <= hdr_now[k];
         end
      end
   end

   // frame buffer
   always_ff @(posedge clock) begin
      if (accept && room) begin
         mem[length_ff[AW-1:0]] <= req_rx_byte;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/mbrs_queue.sv -----
// two-entry request queue between receive and reply sides
// depends on mbrs_pkg
`default_nettype none
module mbrs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mbrs_pkg::job_type push_job,
   output logic                   full,
   output logic                   valid,
   input  wire logic              pop,
   output mbrs_pkg::job_type      head
);
   mbrs_pkg::job_type slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full  = count_ff == 2'd2;
   assign valid = count_ff != 2'd0;
   assign head  = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mbrs_back.sv -----
// reply side: holding registers, write sequencing and reply byte stream with crc
// depends on mbrs_pkg
`default_nettype none
module mbrs_back #(
   parameter int REG_COUNT = 16,
   parameter int AW        = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        slave_id,
   input  wire logic              job_valid,
   input  wire mbrs_pkg::job_type job,
   output logic                   pop,
   output logic                   multi_done,
   output logic [AW-1:0]          rd_addr,
   input  wire logic [7:0]        rd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_tx_last
);
   localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   mbrs_pkg::back_state_type state_ff, state_in;
   mbrs_pkg::job_type        job_ff, job_in;
   logic [15:0]   regs_ff [REG_COUNT];
   logic [5:0]    cnt_ff, cnt_in;
   logic [15:0]   crc_ff, crc_in;
   logic [IW-1:0] rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [4:0]    wcnt_ff, wcnt_in;
   logic [7:0]    hi_ff, hi_in;
   logic          rsp_valid_ff, rsp_valid_in, out_free, load;
   logic [7:0]    byte_val;
   logic          last_val;
   logic          reg_we;
   logic [IW-1:0] reg_waddr;
   logic [15:0]   reg_wdata, rd_word;
   logic [4:0]    qty;
   logic [5:0]    data_last;
   logic [7:0]    func;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign qty       = job_ff.qty_lo[4:0];
   assign data_last = {qty, 1'b0} - 6'd1;
   assign rd_word   = regs_ff[rptr_ff];
   assign rd_addr   = AW'(mbrs_pkg::WDATA_OFFSET) + AW'({wcnt_ff, 1'b0})
                      + AW'(state_ff == mbrs_pkg::ST_WR_HI);

   always_comb begin
      case (job_ff.kind)
         mbrs_pkg::KIND_SINGLE: func = mbrs_pkg::FUNC_WRITE_SINGLE;
         mbrs_pkg::KIND_MULTI:  func = mbrs_pkg::FUNC_WRITE_MULTI;
         default:               func = mbrs_pkg::FUNC_READ_HOLD;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      cnt_in     = cnt_ff;
      crc_in     = crc_ff;
      rptr_in    = rptr_ff;
      wptr_in    = wptr_ff;
      wcnt_in    = wcnt_ff;
      hi_in      = hi_ff;
      pop        = 1'b0;
      multi_done = 1'b0;
      reg_we     = 1'b0;
      reg_waddr  = wptr_ff;
      reg_wdata  = {hi_ff, rd_data};
      load       = 1'b0;
      byte_val   = 8'd0;
      last_val   = 1'b0;
      case (state_ff)
         mbrs_pkg::ST_IDLE: begin
            if (job_valid) begin
               pop     = 1'b1;
               job_in  = job;
               cnt_in  = '0;
               crc_in  = mbrs_pkg::CRC_INIT;
               rptr_in = job.addr_lo[IW-1:0];
               wptr_in = job.addr_lo[IW-1:0];
               wcnt_in = '0;
               case (job.kind)
                  mbrs_pkg::KIND_MULTI: state_in = mbrs_pkg::ST_WR_ISSUE;
                  mbrs_pkg::KIND_SINGLE: begin
                     reg_we    = 1'b1;
                     reg_waddr = job.addr_lo[IW-1:0];
                     reg_wdata = {job.qty_hi, job.qty_lo};
                     state_in  = mbrs_pkg::ST_HEAD;
                  end
                  default: state_in = mbrs_pkg::ST_HEAD;
               endcase
            end
         end
         mbrs_pkg::ST_WR_ISSUE: state_in = mbrs_pkg::ST_WR_HI;
         mbrs_pkg::ST_WR_HI: begin
            hi_in    = rd_data;
            state_in = mbrs_pkg::ST_WR_LO;
         end
         mbrs_pkg::ST_WR_LO: begin
            reg_we  = 1'b1;
            wptr_in = wptr_ff + IW'(1);
            wcnt_in = wcnt_ff + 5'd1;
            if (wcnt_ff + 5'd1 == qty) begin
               multi_done = 1'b1;
               state_in   = mbrs_pkg::ST_HEAD;
            end else begin
               state_in = mbrs_pkg::ST_WR_ISSUE;
            end
         end
         mbrs_pkg::ST_HEAD: begin
            case (cnt_ff)
               6'd0: byte_val = slave_id;
               6'd1: byte_val = func;
               6'd2: byte_val = (job_ff.kind == mbrs_pkg::KIND_READ) ?
                                {job_ff.qty_lo[6:0], 1'b0} : job_ff.addr_hi;
               6'd3: byte_val = job_ff.addr_lo;
               6'd4: byte_val = job_ff.qty_hi;
               default: byte_val = job_ff.qty_lo;
            endcase
            if (out_free) begin
               load   = 1'b1;
               crc_in = mbrs_pkg::crc_fold(crc_ff, byte_val);
               cnt_in = cnt_ff + 6'd1;
               if (job_ff.kind == mbrs_pkg::KIND_READ && cnt_ff == 6'd2) begin
                  cnt_in   = '0;
                  state_in = mbrs_pkg::ST_DATA;
               end else if (cnt_ff == 6'd5) begin
                  state_in = mbrs_pkg::ST_CRC_LO;
               end
            end
         end
         mbrs_pkg::ST_DATA: begin
            byte_val = cnt_ff[0] ? rd_word[7:0] : rd_word[15:8];
            if (out_free) begin
               load   = 1'b1;
               crc_in = mbrs_pkg::crc_fold(crc_ff, byte_val);
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[0]) begin
                  rptr_in = rptr_ff + IW'(1);
               end
               if (cnt_ff == data_last) begin
                  state_in = mbrs_pkg::ST_CRC_LO;
               end
            end
         end
         mbrs_pkg::ST_CRC_LO: begin
            byte_val = crc_ff[7:0];
            if (out_free) begin
               load     = 1'b1;
               state_in = mbrs_pkg::ST_CRC_HI;
            end
         end
         mbrs_pkg::ST_CRC_HI: begin
            byte_val = crc_ff[15:8];
            last_val = 1'b1;
            if (out_free) begin
               load     = 1'b1;
               state_in = mbrs_pkg::ST_IDLE;
            end
         end
         default: state_in = mbrs_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbrs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      cnt_ff  <= cnt_in;
      crc_ff  <= crc_in;
      rptr_ff <= rptr_in;
      wptr_ff <= wptr_in;
      wcnt_ff <= wcnt_in;
      hi_ff   <= hi_in;
      if (load) begin
         rsp_tx_byte <= byte_val;
         rsp_tx_last <= last_val;
      end
   end

   // holding registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < REG_COUNT; k++) begin
            regs_ff[k] <= 16'd0;
         end
      end else if (reg_we) begin
         regs_ff[reg_waddr] <= reg_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- rtl/modbus_rtu_register_slave_core.sv -----
// Modbus RTU slave serving a store of 16-bit holding registers.
// Request channel (req_): one received line byte per request, req_frame_end
// set on the byte after which the line went idle. Response channel (rsp_):
// reply bytes in send order, rsp_tx_last set on the final crc byte.
// csr_ writes the own slave address (reset 1); csr_ready is always high.
// Unless stalled, mid-frame bytes are taken one per cycle into the frame
// buffer while the crc is folded in. The frame-end byte is checked in the
// same cycle and, if it asks for a served function, queued for the reply
// sequencer. The sequencer emits one reply byte per cycle while rsp is not
// stalled: up to 37 bytes for a read, 8 for either write. Write multiple
// first steps through ST_WR_ISSUE, ST_WR_HI and ST_WR_LO for each
// register, reading data words out of the frame buffer, and the request
// side stalls until those reads are done. Up to two checked frames can
// wait in the queue; the request side stalls when full.
// Reset clears the receive state, the queue and all holding registers.
// A stalled response byte holds until taken.
`default_nettype none
module modbus_rtu_register_slave_core #(
   parameter int REG_COUNT   = 16,
   parameter int FRAME_BYTES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_tx_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_slave_id
);
   localparam int AW = $clog2(FRAME_BYTES);

   logic              [7:0] slave_id_ff;
   logic              q_full, q_valid, push, pop, multi_done;
   mbrs_pkg::job_type push_job, head_job;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_data;

   assign csr_ready = 1'b1;

   // slave address register
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff <= 8'd1;
      end else if (csr_valid) begin
         slave_id_ff <= csr_slave_id;
      end
   end

   mbrs_front #(.FRAME_BYTES(FRAME_BYTES), .REG_COUNT(REG_COUNT), .AW(AW)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte, .req_frame_end,
      .slave_id(slave_id_ff), .queue_full(q_full), .push, .push_job,
      .multi_done, .rd_addr, .rd_data
   );

   mbrs_queue u_queue (
      .clock, .reset, .push, .push_job, .full(q_full), .valid(q_valid),
      .pop, .head(head_job)
   );

   mbrs_back #(.REG_COUNT(REG_COUNT), .AW(AW)) u_back (
      .clock, .reset, .slave_id(slave_id_ff), .job_valid(q_valid), .job(head_job),
      .pop, .multi_done, .rd_addr, .rd_data, .rsp_valid, .rsp_stall,
      .rsp_tx_byte, .rsp_tx_last
   );

endmodule
`default_nettype wire

// ----- bench/modbus_rtu_register_slave_core_tb.sv -----
// testbench for the modbus rtu register slave core: drives request bytes,
// predicts reply bytes and checks them; depends on rtl/mbrs_pkg.sv and the core
`timescale 1ns / 100ps
module modbus_rtu_register_slave_core_tb;

   localparam int REGS = 16;
   localparam int FBYTES = 64;
   localparam int WATCHDOG_CYCLES = 20000;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } reply_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_frame_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_slave_id = 8'h01;

   // predictor state
   logic [7:0]  own_id;
   logic [7:0]  rx_frame [FBYTES];
   int          rx_count;
   logic [15:0] rx_crc;
   logic        rx_overflow;
   logic [15:0] regs_model [REGS];
   reply_byte_type reply_queue [$];

   int  errors = 0;
   int  replies_seen = 0;
   int  idle_cycles = 0;
   bit  idling_on = 1'b1;
   int  frames_sent = 0;

   always #6 clock = ~clock;

   modbus_rtu_register_slave_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rx_byte(req_rx_byte), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tx_byte(rsp_tx_byte), .rsp_tx_last(rsp_tx_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_slave_id(csr_slave_id)
   );

   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [15:0] frame_word(int i);
      return {rx_frame[i], rx_frame[i + 1]};
   endfunction

   // queue a reply with its crc trailer
   task automatic queue_reply(input logic [7:0] r [$]);
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (r[i]) begin
         c = crc_step(c, r[i]);
         reply_queue.push_back('{r[i], 1'b0});
      end
      reply_queue.push_back('{c[7:0], 1'b0});
      reply_queue.push_back('{c[15:8], 1'b1});
   endtask

   // evaluate a completed frame
   task automatic serve_frame();
      logic [7:0] r [$];
      int a, q;
      if (rx_count < 4 || rx_frame[0] != own_id || rx_crc != 16'h0000) return;
      a = frame_word(2);
      q = frame_word(4);
      case (rx_frame[1])
         mbrs_pkg::FUNC_READ_HOLD: begin
            if (rx_count != 8 || q == 0 || a + q > REGS) return;
            r = '{own_id, mbrs_pkg::FUNC_READ_HOLD, 8'(2 * q)};
            for (int i = 0; i < q; i++) begin
               r.push_back(regs_model[a + i][15:8]);
               r.push_back(regs_model[a + i][7:0]);
            end
            queue_reply(r);
         end
         mbrs_pkg::FUNC_WRITE_MULTI: begin
            if (rx_count < 9 || q == 0 || a + q > REGS) return;
            if (rx_count != 9 + 2 * q || rx_frame[6] != 8'(2 * q)) return;
            for (int i = 0; i < q; i++) regs_model[a + i] = frame_word(7 + 2 * i);
            r = '{own_id, mbrs_pkg::FUNC_WRITE_MULTI, rx_frame[2], rx_frame[3],
                  rx_frame[4], rx_frame[5]};
            queue_reply(r);
         end
         mbrs_pkg::FUNC_WRITE_SINGLE: begin
            if (rx_count != 8 || a >= REGS) return;
            regs_model[a] = q[15:0];
            for (int i = 0; i < 6; i++) r.push_back(rx_frame[i]);
            queue_reply(r);
         end
         default: ;
      endcase
   endtask

   // predictor step for one accepted request
   task automatic predict_request(input logic [7:0] b, input logic fend);
      if (rx_count < FBYTES) begin
         rx_frame[rx_count] = b;
         rx_count++;
      end else begin
         rx_overflow = 1'b1;
      end
      rx_crc = crc_step(rx_crc, b);
      if (fend) begin
         if (!rx_overflow) serve_frame();
         rx_count = 0;
         rx_crc = 16'hFFFF;
         rx_overflow = 1'b0;
      end
   endtask

   // send one request byte, sometimes after a random gap
   task automatic send_byte(input logic [7:0] b, input logic fend);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_end <= fend;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(b, fend);
      @(negedge clock);
   endtask

   // drop request valid and wait for the next falling clock edge
   task automatic req_idle();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // send a frame, optionally with a crc appended, good or corrupted
   task automatic send_frame(input logic [7:0] body [$], input bit add_crc,
                             input bit corrupt);
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (body[i]) c = crc_step(c, body[i]);
      if (corrupt) c = c ^ 16'h0100;
      if (add_crc) begin
         body.push_back(c[7:0]);
         body.push_back(c[15:8]);
      end
      foreach (body[i]) send_byte(body[i], i == body.size() - 1);
      frames_sent++;
   endtask

   task automatic wait_drained();
      req_idle();
      while (reply_queue.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_slave_id(input logic [7:0] id);
      wait_drained();
      csr_valid <= 1'b1;
      csr_slave_id <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      own_id = id;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response sink stall pattern
   always @(negedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall) begin
         if ($urandom_range(0, 3) == 0) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_stall <= 1'b1;
      end
   end

   // reply checker and watchdog
   always @(posedge clock) begin
      reply_byte_type exp_b;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            replies_seen++;
            if (reply_queue.size() == 0) begin
               $error("unexpected reply byte %h", rsp_tx_byte);
               errors++;
            end else begin
               exp_b = reply_queue.pop_front();
               if (rsp_tx_byte !== exp_b.tx_byte) begin
                  $error("tx_byte expected %h actual %h", exp_b.tx_byte, rsp_tx_byte);
                  errors++;
               end
               if (rsp_tx_last !== exp_b.tx_last) begin
                  $error("tx_last expected %b actual %b", exp_b.tx_last, rsp_tx_last);
                  errors++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic void hdr(ref logic [7:0] f [$], input logic [7:0] id,
                               input logic [7:0] fn, input int a, input int q);
      f = '{id, fn, 8'(a >> 8), 8'(a), 8'(q >> 8), 8'(q)};
   endfunction

   // directed: each function, span extremes, short and overlong frames
   task automatic test_directed();
      logic [7:0] f [$];
      hdr(f, 8'h01, mbrs_pkg::FUNC_WRITE_SINGLE, 15, 16'hFFFF); send_frame(f, 1, 0);
      hdr(f, 8'h01, mbrs_pkg::FUNC_WRITE_MULTI, 0, 2);
      f.push_back(8'd4);
      for (int i = 0; i < 4; i++) f.push_back(8'($urandom));
      send_frame(f, 1, 0);
      hdr(f, 8'h01, mbrs_pkg::FUNC_READ_HOLD, 0, 16); send_frame(f, 1, 0);
      hdr(f, 8'h01, mbrs_pkg::FUNC_READ_HOLD, 15, 2); send_frame(f, 1, 0);
      f = '{8'h01, mbrs_pkg::FUNC_READ_HOLD}; send_frame(f, 1, 0);
      // overlong frame, one byte past the buffer, otherwise valid-looking
      hdr(f, 8'h01, mbrs_pkg::FUNC_READ_HOLD, 0, 1);
      for (int i = 0; i < FBYTES - 7; i++) f.push_back(8'($urandom));
      send_frame(f, 1, 0);
   endtask

   // random frames, mostly well formed
   task automatic test_random(input int n);
      logic [7:0] f [$];
      int a, q, kind;
      for (int k = 0; k < n; k++) begin
         kind = $urandom_range(0, 9);
         q = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
         a = $urandom_range(0, REGS - q);
         if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 65535);
         case (kind)
            0, 1, 2: begin
               hdr(f, own_id, mbrs_pkg::FUNC_READ_HOLD, a, q);
               send_frame(f, 1, $urandom_range(0, 15) == 0);
            end
            3, 4, 5: begin
               hdr(f, own_id, mbrs_pkg::FUNC_WRITE_SINGLE, $urandom_range(0, 19),
                   $urandom);
               send_frame(f, 1, $urandom_range(0, 15) == 0);
            end
            6, 7, 8: begin
               hdr(f, own_id, mbrs_pkg::FUNC_WRITE_MULTI, a, q);
               f.push_back(8'(2 * q));
               for (int i = 0; i < 2 * q; i++) f.push_back(8'($urandom));
               send_frame(f, 1, $urandom_range(0, 15) == 0);
            end
            default: begin
               f = {};
               repeat ($urandom_range(1, 12)) f.push_back(8'($urandom));
               if ($urandom_range(0, 1)) f[0] = own_id;
               send_frame(f, $urandom_range(0, 1), 0);
            end
         endcase
      end
   endtask

   initial begin
      own_id = 8'h01;
      rx_count = 0;
      rx_crc = 16'hFFFF;
      rx_overflow = 1'b0;
      foreach (regs_model[i]) regs_model[i] = 16'h0000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      write_slave_id(8'd247);
      test_random(1);
      // sender holds until all replies are back
      wait_drained();
      write_slave_id(8'($urandom_range(2, 246)));
      test_random(1);
      idling_on = 1'b0;
      test_random(1);

      wait_drained();
      $display("covered %0d frames of read, write single, write multiple and rejects,",
               frames_sent);
      $display("%0d reply bytes checked across three slave addresses", replies_seen);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
